FILE: rtl/core/qtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtc_pkg;

   // result coefficient width, unsigned fixed point
   localparam int OUT_W = 32;

   // saturated coefficient value
   localparam logic [OUT_W-1:0] COEFF_SAT = '1;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = OUT_W;

   // one divider lane per corner
   localparam int NUM_LANES = 4;

endpackage

`default_nettype wire

FILE: rtl/core/qtc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qtc_req_if #(
   parameter int COORD_WIDTH = 32
) ();

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] corner0_x;
   logic signed [COORD_WIDTH-1:0] corner0_y;
   logic signed [COORD_WIDTH-1:0] corner1_x;
   logic signed [COORD_WIDTH-1:0] corner1_y;
   logic signed [COORD_WIDTH-1:0] corner2_x;
   logic signed [COORD_WIDTH-1:0] corner2_y;
   logic signed [COORD_WIDTH-1:0] corner3_x;
   logic signed [COORD_WIDTH-1:0] corner3_y;

   modport source (
      output valid, corner0_x, corner0_y, corner1_x, corner1_y,
             corner2_x, corner2_y, corner3_x, corner3_y,
      input  ready
   );

   modport sink (
      input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
             corner2_x, corner2_y, corner3_x, corner3_y,
      output ready
   );

endinterface

`default_nettype wire

FILE: rtl/core/qtc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qtc_rsp_if ();

   logic                       valid;
   logic                       ready;
   logic [qtc_pkg::OUT_W-1:0]  coeff0;
   logic [qtc_pkg::OUT_W-1:0]  coeff1;
   logic [qtc_pkg::OUT_W-1:0]  coeff2;
   logic [qtc_pkg::OUT_W-1:0]  coeff3;
   logic                       degenerate;

   modport source (
      output valid, coeff0, coeff1, coeff2, coeff3, degenerate,
      input  ready
   );

   modport sink (
      input  valid, coeff0, coeff1, coeff2, coeff3, degenerate,
      output ready
   );

endinterface

`default_nettype wire

FILE: rtl/core/quad_texture_coeff_core.sv
// quad_texture_coeff_core: projective texture q coefficients of a quad
//
// req_chan carries the four corners of one quad in strip order (signed
// fixed point, FRAC_BITS fraction). rsp_chan returns one transaction per
// request: four unsigned Q(32-FRAC_BITS).FRAC_BITS coefficients, each
// saturating at all ones, and a degenerate flag for parallel diagonals or
// a crossing on a corner.
// Pipeline: 8 arithmetic stages (differences, split multiplies, cross
// products, magnitudes, sums), a divider setup stage, 32 restoring divider
// stages and the output register. The divider pipeline computes one
// quotient bit per stage in four parallel lanes.
// Throughput: one transaction per cycle while rsp_chan.ready stays high.
// Stalls: every stage carries a valid bit and holds while it is full and
// the next stage is held, so a bubble anywhere lets req_chan.ready stay high
// while a finished result waits on rsp_chan. Nothing is lost or repeated.
// Reset (synchronous, active high) empties all stages; data is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module quad_texture_coeff_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire        clock,
   input  wire        reset,
   qtc_req_if.sink    req_chan,
   qtc_rsp_if.source  rsp_chan
);

   localparam int OUT_W  = qtc_pkg::OUT_W;
   localparam int LANES  = qtc_pkg::NUM_LANES;
   localparam int STEPS  = qtc_pkg::DIV_STEPS;
   localparam int DW     = COORD_WIDTH + 1;
   localparam int HL     = (DW + 1) / 2;
   localparam int HH     = DW - HL;
   localparam int PW     = 2 * DW;
   localparam int CRW    = PW + 1;
   localparam int EW     = CRW + 1;
   localparam int MW     = EW;
   localparam int SW     = MW + 1;
   localparam int RW     = MW + 1;
   localparam int SH     = OUT_W - FRAC_BITS;
   localparam int CMPW   = MW + SH + 1;
   localparam int P_INIT = 8;
   localparam int P_OUT  = P_INIT + STEPS + 1;
   localparam int NSTG   = P_OUT + 1;

   typedef struct packed {
      logic [RW-1:0]    rem;
      logic [MW-1:0]    near;
      logic [OUT_W-1:0] low;
      logic [OUT_W-1:0] quo;
      logic             sat;
   } div_lane_type;

   // stage valid bits and per-stage advance
   logic [NSTG-1:0] valid_ff, valid_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || rsp_chan.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      for (int i = 0; i < NSTG; i++) begin
         if (en[i]) begin
            valid_in[i] = (i == 0) ? req_chan.valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = en[0];

   // stage 0: diagonal and side vectors
   logic signed [DW-1:0] vec_ff[6], vec_in[6];

   always_comb begin
      vec_in[0] = $signed({req_chan.corner3_x[COORD_WIDTH-1], req_chan.corner3_x})
                - $signed({req_chan.corner0_x[COORD_WIDTH-1], req_chan.corner0_x});
      vec_in[1] = $signed({req_chan.corner3_y[COORD_WIDTH-1], req_chan.corner3_y})
                - $signed({req_chan.corner0_y[COORD_WIDTH-1], req_chan.corner0_y});
      vec_in[2] = $signed({req_chan.corner2_x[COORD_WIDTH-1], req_chan.corner2_x})
                - $signed({req_chan.corner1_x[COORD_WIDTH-1], req_chan.corner1_x});
      vec_in[3] = $signed({req_chan.corner2_y[COORD_WIDTH-1], req_chan.corner2_y})
                - $signed({req_chan.corner1_y[COORD_WIDTH-1], req_chan.corner1_y});
      vec_in[4] = $signed({req_chan.corner1_x[COORD_WIDTH-1], req_chan.corner1_x})
                - $signed({req_chan.corner0_x[COORD_WIDTH-1], req_chan.corner0_x});
      vec_in[5] = $signed({req_chan.corner1_y[COORD_WIDTH-1], req_chan.corner1_y})
                - $signed({req_chan.corner0_y[COORD_WIDTH-1], req_chan.corner0_y});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vec_ff <= vec_in;
      end
   end

   // stage 1: split partial products of the six cross-product terms
   // order: ax*by, ay*bx, wx*by, wy*bx, wx*ay, wy*ax
   logic signed [DW-1:0]   mul_a[6], mul_b[6];
   logic [2*HL-1:0]        ll_ff[6], ll_in[6];
   logic signed [DW:0]     lh_ff[6], lh_in[6];
   logic signed [DW:0]     hl_ff[6], hl_in[6];
   logic signed [2*HH-1:0] hh_ff[6], hh_in[6];

   always_comb begin
      mul_a[0] = vec_ff[0]; mul_b[0] = vec_ff[3];
      mul_a[1] = vec_ff[1]; mul_b[1] = vec_ff[2];
      mul_a[2] = vec_ff[4]; mul_b[2] = vec_ff[3];
      mul_a[3] = vec_ff[5]; mul_b[3] = vec_ff[2];
      mul_a[4] = vec_ff[4]; mul_b[4] = vec_ff[1];
      mul_a[5] = vec_ff[5]; mul_b[5] = vec_ff[0];
      for (int p = 0; p < 6; p++) begin
         ll_in[p] = mul_a[p][HL-1:0] * mul_b[p][HL-1:0];
         lh_in[p] = $signed({1'b0, mul_a[p][HL-1:0]}) * $signed(mul_b[p][DW-1:HL]);
         hl_in[p] = $signed(mul_a[p][DW-1:HL]) * $signed({1'b0, mul_b[p][HL-1:0]});
         hh_in[p] = $signed(mul_a[p][DW-1:HL]) * $signed(mul_b[p][DW-1:HL]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   // stage 2: outer terms packed, middle terms summed
   logic signed [PW-1:0] cat_ff[6], cat_in[6];
   logic signed [DW+1:0] mid_ff[6], mid_in[6];

   always_comb begin
      for (int p = 0; p < 6; p++) begin
         cat_in[p] = $signed({hh_ff[p], ll_ff[p]});
         mid_in[p] = $signed({lh_ff[p][DW], lh_ff[p]}) + $signed({hl_ff[p][DW], hl_ff[p]});
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         cat_ff <= cat_in;
         mid_ff <= mid_in;
      end
   end

   // stage 3: full products
   logic signed [PW-1:0] prod_ff[6], prod_in[6];

   always_comb begin
      for (int p = 0; p < 6; p++) begin
         prod_in[p] = cat_ff[p] + (PW'(mid_ff[p]) <<< HL);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         prod_ff <= prod_in;
      end
   end

   // stage 4: cross products d, nt, ns
   logic signed [CRW-1:0] cross_ff[3], cross_in[3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_in[k] = CRW'(prod_ff[2*k]) - CRW'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         cross_ff <= cross_in;
      end
   end

   // stage 5: far segments d - nt, d - ns; parallel diagonal check
   logic signed [EW-1:0] seg_ff[4], seg_in[4];
   logic                 dzero5_ff, dzero5_in;

   always_comb begin
      seg_in[0] = EW'(cross_ff[1]);
      seg_in[1] = EW'(cross_ff[0]) - EW'(cross_ff[1]);
      seg_in[2] = EW'(cross_ff[2]);
      seg_in[3] = EW'(cross_ff[0]) - EW'(cross_ff[2]);
      dzero5_in = (cross_ff[0] == '0);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         seg_ff    <= seg_in;
         dzero5_ff <= dzero5_in;
      end
   end

   // stage 6: magnitudes t0, t1, s0, s1
   logic [MW-1:0] mag_ff[4], mag_in[4];
   logic          dzero6_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mag_in[k] = seg_ff[k][EW-1] ? MW'(-seg_ff[k]) : MW'(seg_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         mag_ff    <= mag_in;
         dzero6_ff <= dzero5_ff;
      end
   end

   // stage 7: lane near segment and near plus far
   logic [SW-1:0] sum_ff[LANES], sum_in[LANES];
   logic [MW-1:0] near_ff[LANES], near_in[LANES];
   logic          dzero7_ff;

   always_comb begin
      near_in[0] = mag_ff[1]; sum_in[0] = SW'(mag_ff[1]) + SW'(mag_ff[0]);
      near_in[1] = mag_ff[3]; sum_in[1] = SW'(mag_ff[3]) + SW'(mag_ff[2]);
      near_in[2] = mag_ff[2]; sum_in[2] = SW'(mag_ff[2]) + SW'(mag_ff[3]);
      near_in[3] = mag_ff[0]; sum_in[3] = SW'(mag_ff[0]) + SW'(mag_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         sum_ff    <= sum_in;
         near_ff   <= near_in;
         dzero7_ff <= dzero6_ff;
      end
   end

   // divider pipeline: entry 0 is setup, entries 1..STEPS each yield one bit
   div_lane_type div_ff[STEPS+1][LANES];
   div_lane_type div_in[STEPS+1][LANES];
   logic         deg_ff[STEPS+1];
   logic         deg_in[STEPS+1];

   // setup: overflow test, leading remainder, low numerator bits
   // then the restoring steps
   always_comb begin
      logic          ovf;
      logic          nzero;
      logic          anyz;
      logic [RW-1:0] trial;
      logic          ge;
      anyz = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         ovf   = CMPW'(sum_ff[l]) >= (CMPW'(near_ff[l]) << SH);
         nzero = (near_ff[l] == '0);
         anyz  = anyz || nzero;
         div_in[0][l].rem  = RW'(sum_ff[l] >> SH);
         div_in[0][l].near = near_ff[l];
         div_in[0][l].low  = OUT_W'({sum_ff[l], {FRAC_BITS{1'b0}}});
         div_in[0][l].quo  = '0;
         div_in[0][l].sat  = ovf || nzero || dzero7_ff;
      end
      deg_in[0] = anyz || dzero7_ff;
      for (int k = 1; k <= STEPS; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {div_ff[k-1][l].rem[RW-2:0], div_ff[k-1][l].low[OUT_W-1]};
            ge    = trial >= {1'b0, div_ff[k-1][l].near};
            div_in[k][l].rem  = ge ? trial - {1'b0, div_ff[k-1][l].near} : trial;
            div_in[k][l].near = div_ff[k-1][l].near;
            div_in[k][l].low  = {div_ff[k-1][l].low[OUT_W-2:0], 1'b0};
            div_in[k][l].quo  = {div_ff[k-1][l].quo[OUT_W-2:0], ge};
            div_in[k][l].sat  = div_ff[k-1][l].sat;
         end
         deg_in[k] = deg_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= STEPS; k++) begin
         if (en[P_INIT+k]) begin
            div_ff[k] <= div_in[k];
            deg_ff[k] <= deg_in[k];
         end
      end
   end

   // output register
   logic [OUT_W-1:0] coeff_ff[LANES], coeff_in[LANES];
   logic             degen_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         coeff_in[l] = div_ff[STEPS][l].sat ? qtc_pkg::COEFF_SAT : div_ff[STEPS][l].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en[P_OUT]) begin
         coeff_ff <= coeff_in;
         degen_ff <= deg_ff[STEPS];
      end
   end

   assign rsp_chan.valid      = valid_ff[P_OUT];
   assign rsp_chan.coeff0     = coeff_ff[0];
   assign rsp_chan.coeff1     = coeff_ff[1];
   assign rsp_chan.coeff2     = coeff_ff[2];
   assign rsp_chan.coeff3     = coeff_ff[3];
   assign rsp_chan.degenerate = degen_ff;

   // checks
   localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRAC_BITS;

   // a sound quad never yields a coefficient below one
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.degenerate |->
         rsp_chan.coeff0 >= ONE_FX && rsp_chan.coeff1 >= ONE_FX &&
         rsp_chan.coeff2 >= ONE_FX && rsp_chan.coeff3 >= ONE_FX)
      else $error("coefficient below one on non-degenerate quad");

   // an empty output stage lets every stage advance
   assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request stalled with empty output stage");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CW   = 32;
   localparam int FB   = 16;
   localparam int LAT  = 41;

   typedef struct {
      logic signed [CW-1:0] x[4];
      logic signed [CW-1:0] y[4];
   } quad_type;

   typedef struct {
      logic [qtc_pkg::OUT_W-1:0] coeff[4];
      logic                      degen;
   } coeff_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qtc_req_if #(.COORD_WIDTH(CW)) req_chan ();
   qtc_rsp_if                     rsp_chan ();

   quad_texture_coeff_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   coeff_set_type coeff_queue[$];
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            error_count   = 0;
   int            quads_sent    = 0;
   int            results_seen  = 0;
   int            degen_seen    = 0;
   int            sat_seen      = 0;

   // (far + near) / near in fixed point, saturating
   function automatic logic [qtc_pkg::OUT_W-1:0] seg_ratio(logic [127:0] far_len,
                                                           logic [127:0] near_len);
      logic [127:0] quo;
      if (near_len == 0) return qtc_pkg::COEFF_SAT;
      quo = ((far_len + near_len) << FB) / near_len;
      if (quo > 128'hFFFF_FFFF) return qtc_pkg::COEFF_SAT;
      return quo[qtc_pkg::OUT_W-1:0];
   endfunction

   function automatic logic [127:0] mag(logic signed [127:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // coefficients from the diagonal crossing, exact integer ratios
   function automatic coeff_set_type predict_coeffs(quad_type q);
      coeff_set_type r;
      logic signed [127:0] ax, ay, bx, by, wx, wy, d, nt, ns;
      logic [127:0] t0, t1, s0, s1;
      ax = 128'(q.x[3]) - 128'(q.x[0]);
      ay = 128'(q.y[3]) - 128'(q.y[0]);
      bx = 128'(q.x[2]) - 128'(q.x[1]);
      by = 128'(q.y[2]) - 128'(q.y[1]);
      wx = 128'(q.x[1]) - 128'(q.x[0]);
      wy = 128'(q.y[1]) - 128'(q.y[0]);
      d  = ax * by - ay * bx;
      nt = wx * by - wy * bx;
      ns = wx * ay - wy * ax;
      if (d == 0) begin
         foreach (r.coeff[i]) r.coeff[i] = qtc_pkg::COEFF_SAT;
         r.degen = 1'b1;
         return r;
      end
      t0 = mag(nt);
      t1 = mag(d - nt);
      s0 = mag(ns);
      s1 = mag(d - ns);
      r.degen    = (t0 == 0) || (t1 == 0) || (s0 == 0) || (s1 == 0);
      r.coeff[0] = seg_ratio(t0, t1);
      r.coeff[1] = seg_ratio(s0, s1);
      r.coeff[2] = seg_ratio(s1, s0);
      r.coeff[3] = seg_ratio(t1, t0);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   // send one quad, idling beforehand at the current rate
   task automatic send_quad(input quad_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.corner0_x <= q.x[0];
      req_chan.corner0_y <= q.y[0];
      req_chan.corner1_x <= q.x[1];
      req_chan.corner1_y <= q.y[1];
      req_chan.corner2_x <= q.x[2];
      req_chan.corner2_y <= q.y[2];
      req_chan.corner3_x <= q.x[3];
      req_chan.corner3_y <= q.y[3];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      coeff_queue.push_back(predict_coeffs(q));
      quads_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (coeff_queue.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls and checking of each transaction
   always @(posedge clock) begin
      coeff_set_type exp_set;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (rsp_chan.degenerate) degen_seen++;
            if (rsp_chan.coeff0 == qtc_pkg::COEFF_SAT) sat_seen++;
            if (coeff_queue.size() == 0) begin
               report_mismatch("result with no quad outstanding");
            end else begin
               exp_set = coeff_queue.pop_front();
               if (rsp_chan.coeff0 !== exp_set.coeff[0])
                  report_mismatch($sformatf("coeff0 %h exp %h", rsp_chan.coeff0,
                                            exp_set.coeff[0]));
               if (rsp_chan.coeff1 !== exp_set.coeff[1])
                  report_mismatch($sformatf("coeff1 %h exp %h", rsp_chan.coeff1,
                                            exp_set.coeff[1]));
               if (rsp_chan.coeff2 !== exp_set.coeff[2])
                  report_mismatch($sformatf("coeff2 %h exp %h", rsp_chan.coeff2,
                                            exp_set.coeff[2]));
               if (rsp_chan.coeff3 !== exp_set.coeff[3])
                  report_mismatch($sformatf("coeff3 %h exp %h", rsp_chan.coeff3,
                                            exp_set.coeff[3]));
               if (rsp_chan.degenerate !== exp_set.degen)
                  report_mismatch($sformatf("degenerate %b exp %b",
                                            rsp_chan.degenerate, exp_set.degen));
            end
         end
      end
   end

   function automatic quad_type make_quad(int x0, int y0, int x1, int y1,
                                          int x2, int y2, int x3, int y3);
      quad_type q;
      q.x[0] = x0; q.y[0] = y0; q.x[1] = x1; q.y[1] = y1;
      q.x[2] = x2; q.y[2] = y2; q.x[3] = x3; q.y[3] = y3;
      return q;
   endfunction

   // quad in strip order around a random center, random size
   function automatic quad_type strip_quad();
      quad_type q;
      int cx, cy, span;
      span = 1 << $urandom_range(30, 4);
      cx   = $signed($urandom()) >>> $urandom_range(8, 1);
      cy   = $signed($urandom()) >>> $urandom_range(8, 1);
      for (int i = 0; i < 4; i++) begin
         q.x[i] = cx + ((i % 2) ? 1 : -1) * $signed(32'($urandom_range(span, 1)));
         q.y[i] = cy + ((i / 2) ? 1 : -1) * $signed(32'($urandom_range(span, 1)));
      end
      return q;
   endfunction

   function automatic quad_type noise_quad();
      quad_type q;
      for (int i = 0; i < 4; i++) begin
         q.x[i] = $urandom();
         q.y[i] = $urandom();
      end
      return q;
   endfunction

   // extremes, parallel diagonals, crossing on a corner, large ratios
   task automatic test_directed();
      int mx, mn, u;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      u  = 32'h0001_0000;
      send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(make_quad(0, 0, u, 0, 0, u, u, u));
      send_quad(make_quad(mn, mn, mx, mn, mn, mx, mx, mx));
      send_quad(make_quad(mx, mx, mn, mx, mx, mn, mn, mn));
      send_quad(make_quad(mn, mx, mx, mx, mn, mn, mx, mn));
      send_quad(make_quad(-1, -1, -1, -1, -1, -1, -1, -1));
      // parallel diagonals
      send_quad(make_quad(0, 0, 0, u, 2*u, u, 2*u, 0));
      send_quad(make_quad(0, 0, u, u, 2*u, 2*u, 3*u, 3*u));
      // crossing on a corner, and a square crossing at its center
      send_quad(make_quad(0, 0, 0, 0, 2*u, 0, 0, 2*u));
      send_quad(make_quad(0, 0, 2*u, 0, 0, 2*u, 2*u, 2*u));
      send_quad(make_quad(u, u, 0, 2*u, 2*u, 0, 3*u, 3*u));
      // crossing far from center: large ratios
      send_quad(make_quad(0, 0, mx, 1, 1, mx, 1, 1));
      send_quad(make_quad(0, 0, u, -u, -u, u, 1, 1));
      send_quad(make_quad(mn, 0, 0, mn, 0, mx, mx, 0));
      send_quad(make_quad(0, 0, 3*u, 0, 0, u, 3*u, u));
      send_quad(make_quad(1, 0, 0, 1, 2, 1, 1, 2));
      drain_results();
   endtask

   task automatic test_random(input int count, input int s_idle, input int r_idle);
      quad_type q;
      int pick;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 70) q = strip_quad();
         else if (pick < 85) q = noise_quad();
         else begin
            // broken shapes: shared corners or parallel diagonals
            q = strip_quad();
            if (pick < 92) begin
               q.x[$urandom_range(3)] = q.x[0];
               q.y[1] = q.y[0];
               q.x[1] = q.x[0];
            end else begin
               q.x[3] = q.x[0] + (q.x[2] - q.x[1]);
               q.y[3] = q.y[0] + (q.y[2] - q.y[1]);
            end
         end
         send_quad(q);
         // stretch with no idling partway through
         if (n == count / 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == count / 2 + 40) begin
            send_idle_pct = s_idle;
            recv_idle_pct = r_idle;
         end
      end
   endtask

   // sender holds off until the pipeline is empty, then resumes
   task automatic test_hold_off();
      test_random(30, 0, 53);
      drain_results();
      test_random(30, 0, 0);
      drain_results();
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.corner0_x <= '0;
      req_chan.corner0_y <= '0;
      req_chan.corner1_x <= '0;
      req_chan.corner1_y <= '0;
      req_chan.corner2_x <= '0;
      req_chan.corner2_y <= '0;
      req_chan.corner3_x <= '0;
      req_chan.corner3_y <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(550, 15, 53);
      test_random(550, 53, 15);
      test_hold_off();
      test_random(500, 0, 0);
      drain_results();
      repeat (LAT + 20) @(posedge clock);

      $display("run covered %0d quads, %0d results checked, %0d degenerate, %0d saturated",
               quads_sent, results_seen, degen_seen, sat_seen);
      $display("directed corner cases, strip quads, noise and broken shapes, with stalls");
      if (error_count == 0 && coeff_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, coeff_queue.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", coeff_queue.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/qtc_pkg.sv
rtl/core/qtc_req_if.sv
rtl/core/qtc_rsp_if.sv
rtl/core/quad_texture_coeff_core.sv
bench/tb.sv
